// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the method recognizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks an implication property at every rising clock edge outside reset.
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: sv/hmtr_pkg.sv
// Package with the types, codes and method name table of the method recognizer.
package hmtr_pkg;

    localparam int MAX_TOKEN_BYTES_DEF = 16;
    localparam int NUM_METHODS = 19;
    localparam int NAME_BYTES = 9;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef logic [4:0] method_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef logic [NAME_BYTES*8-1:0] name_text_t;

    // Names are right-justified: the last character sits in the low byte.
    localparam name_text_t METHOD_TEXT [NUM_METHODS] = '{
        name_text_t'("GET"),      name_text_t'("PUT"),     name_text_t'("ACL"),
        name_text_t'("POST"),     name_text_t'("HEAD"),    name_text_t'("COPY"),
        name_text_t'("MOVE"),     name_text_t'("LOCK"),    name_text_t'("TRACE"),
        name_text_t'("PATCH"),    name_text_t'("MKCOL"),   name_text_t'("DELETE"),
        name_text_t'("UNLOCK"),   name_text_t'("REPORT"),  name_text_t'("SEARCH"),
        name_text_t'("OPTIONS"),  name_text_t'("COMMENT"), name_text_t'("PROPFIND"),
        name_text_t'("PROPPATCH")
    };

    localparam int METHOD_LEN [NUM_METHODS] = '{
        3, 3, 3, 4, 4, 4, 4, 4, 5, 5, 5, 6, 6, 6, 6, 7, 7, 8, 9
    };

    typedef struct packed {
        logic         hit;
        method_code_t code;
    } match_t;

endpackage

// File: sv/hmtr_in_if.sv
// Byte request channel of the method recognizer.
interface hmtr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// File: sv/hmtr_out_if.sv
// Result request channel of the method recognizer.
interface hmtr_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] method_code;
    logic [1:0] parse_status;

    modport source (output valid, output method_code, output parse_status, input ready);
    modport sink (input valid, input method_code, input parse_status, output ready);
endinterface

// File: sv/hmtr_match.sv
// Parallel compare of the held token against the fixed method names.
module hmtr_match #(
    parameter int LEN_W = 5
) (
    input  logic [hmtr_pkg::NAME_BYTES-1:0][7:0] token,
    input  logic [LEN_W-1:0]                     length,
    output hmtr_pkg::match_t                     result
);
    import hmtr_pkg::*;

    always_comb
    begin
        logic hit_k;
        int   shift;
        result = '0;
        for (int k = 0; k < NUM_METHODS; k++)
        begin
            hit_k = (length == LEN_W'(METHOD_LEN[k]));
            for (int i = 0; i < NAME_BYTES; i++)
            begin
                if (i < METHOD_LEN[k])
                begin
                    shift = 8 * (METHOD_LEN[k] - 1 - i);
                    hit_k = hit_k && (token[i] == METHOD_TEXT[k][shift +: 8]);
                end
            end
            if (hit_k && !result.hit)
            begin
                result.hit  = 1'b1;
                result.code = method_code_t'(k);
            end
        end
    end

endmodule

// File: sv/http_method_token_recognizer_top.sv
// Top level of the HTTP request method token recognizer.
//
// Bytes of a request line enter on the bytes channel, one per request; restart
// marks the first byte of a new request line. Letters are folded to upper case
// and appended to the token. A space closes the token, and one result request
// carries the method code and status on the result channel. A non-space byte
// beyond MAX_TOKEN_BYTES gives the too-long status. After a result, bytes are
// dropped without a result until the next restart.
// Throughput is one byte per cycle while ready is high. A closing byte's result
// is registered in the output register, or in the skid stage if the receiver
// stalls; the name compare is one level of byte comparators against the table.
// Reset clears the token length, the finished flag and the valid flags of both
// output stages; the token bytes and the result fields are not reset.
// When the receiver stalls, one more result is held in a skid stage behind the
// output register; the bytes channel drops ready only while that stage is full.
module http_method_token_recognizer_top #(
    parameter int MAX_TOKEN_BYTES = hmtr_pkg::MAX_TOKEN_BYTES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    hmtr_in_if.sink    bytes,
    hmtr_out_if.source result
);
    import hmtr_pkg::*;
    `include "assert_macros.svh"

    localparam int LEN_W = $clog2(MAX_TOKEN_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_TOKEN_BYTES);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_TOKEN_BYTES);

    logic [MAX_TOKEN_BYTES-1:0][7:0] store_reg;
    logic [LEN_W-1:0]                length_reg, length_next;
    logic                            finished_reg, finished_next;

    logic         out_valid_reg, skid_valid_reg;
    method_code_t out_code_reg, skid_code_reg;
    status_t      out_status_reg, skid_status_reg;

    logic [LEN_W-1:0] length_cur;
    logic             finished_cur;
    logic             fire_in, fire_out, produce, store_we;
    logic [7:0]       folded;
    method_code_t     res_code;
    status_t          res_status;
    match_t           match;

    assign fire_in  = bytes.valid && bytes.ready;
    assign fire_out = result.valid && result.ready;

    assign length_cur   = bytes.restart ? '0 : length_reg;
    assign finished_cur = bytes.restart ? 1'b0 : finished_reg;

    assign folded = (bytes.data_byte >= LOWER_A && bytes.data_byte <= LOWER_Z)
                  ? (bytes.data_byte - CASE_BIT) : bytes.data_byte;

    hmtr_match #(
        .LEN_W (LEN_W)
    ) u_match (
        .token  (store_reg[NAME_BYTES-1:0]),
        .length (length_cur),
        .result (match)
    );

    always_comb
    begin
        produce       = 1'b0;
        store_we      = 1'b0;
        res_code      = '0;
        res_status    = ST_OK;
        length_next   = length_reg;
        finished_next = finished_reg;
        if (fire_in)
        begin
            length_next   = length_cur;
            finished_next = finished_cur;
            if (!finished_cur)
            begin
                if (bytes.data_byte == SPACE_BYTE)
                begin
                    produce       = 1'b1;
                    finished_next = 1'b1;
                    if (length_cur == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else if (match.hit)
                    begin
                        res_status = ST_OK;
                        res_code   = match.code;
                    end
                    else
                    begin
                        res_status = ST_UNKNOWN;
                    end
                end
                else if (length_cur == LEN_FULL)
                begin
                    produce       = 1'b1;
                    finished_next = 1'b1;
                    res_status    = ST_TOO_LONG;
                end
                else
                begin
                    store_we    = 1'b1;
                    length_next = length_cur + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[length_cur[IDX_W-1:0]] <= folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (fire_out || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_out || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_code_reg   <= skid_code_reg;
                out_status_reg <= skid_status_reg;
            end
            else
            begin
                out_code_reg   <= res_code;
                out_status_reg <= res_status;
            end
        end
        else if (produce)
        begin
            skid_code_reg   <= res_code;
            skid_status_reg <= res_status;
        end
    end

    assign bytes.ready         = !skid_valid_reg;
    assign result.valid        = out_valid_reg;
    assign result.method_code  = out_code_reg;
    assign result.parse_status = out_status_reg;

    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid full while output empty")
    `ASSERT_ALWAYS(a_length_bound, length_reg <= LEN_FULL, "token length beyond store depth")
    `ASSERT_IMPL(a_result_sets_finished, (fire_in && produce) |=> finished_reg, "result without finish")

endmodule

// File: tb/http_method_token_recognizer_top_tb.sv
// Self-checking testbench for the HTTP method recognizer: random request lines, checked results.
module http_method_token_recognizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmtr_pkg::*;

    localparam int TOKEN_CAP = 16;
    localparam int BYTE_TARGET = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE = 8'h20;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } byte_req_t;

    typedef struct packed {
        method_code_t code;
        status_t      status;
    } verdict_t;

    string method_names [NUM_METHODS] = '{
        "GET", "PUT", "ACL", "POST", "HEAD", "COPY", "MOVE", "LOCK", "TRACE", "PATCH",
        "MKCOL", "DELETE", "UNLOCK", "REPORT", "SEARCH", "OPTIONS", "COMMENT",
        "PROPFIND", "PROPPATCH"
    };

    logic clk = 1'b0;
    logic rst_n;

    hmtr_in_if  bytes_if ();
    hmtr_out_if result_if ();

    http_method_token_recognizer_top #(.MAX_TOKEN_BYTES(TOKEN_CAP)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes_if),
        .result (result_if)
    );

    byte_req_t  pending_bytes [$];
    verdict_t   expected_verdicts [$];
    logic [7:0] token_bytes [TOKEN_CAP];
    int         held_count;
    bit         token_done;
    int         sent_count;
    int         checked_count;
    int         error_count;
    int         cycle_count;
    int         send_wait;
    int         recv_wait;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_byte(input logic [7:0] raw, input logic first);
        logic [7:0] b;
        verdict_t   v;
        bit         same;
        bit         hit;
        b = raw;
        hit = 1'b0;
        if (first)
        begin
            held_count = 0;
            token_done = 1'b0;
        end
        if (token_done)
            return;
        v.code = '0;
        if (b == ASCII_SPACE)
        begin
            if (held_count == 0)
                v.status = ST_EMPTY;
            else
            begin
                v.status = ST_UNKNOWN;
                for (int k = 0; k < NUM_METHODS; k++)
                begin
                    if (!hit && method_names[k].len() == held_count)
                    begin
                        same = 1'b1;
                        for (int i = 0; i < held_count; i++)
                            if (token_bytes[i] != 8'(method_names[k][i]))
                                same = 1'b0;
                        if (same)
                        begin
                            hit = 1'b1;
                            v.code = method_code_t'(k);
                            v.status = ST_OK;
                        end
                    end
                end
            end
        end
        else if (held_count >= TOKEN_CAP)
            v.status = ST_TOO_LONG;
        else
        begin
            if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z)
                b = b - ASCII_CASE;
            token_bytes[held_count] = b;
            held_count++;
            return;
        end
        token_done = 1'b1;
        expected_verdicts.push_back(v);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic first);
        byte_req_t r;
        r.data = b;
        r.first = first;
        pending_bytes.push_back(r);
    endtask

    function automatic logic [7:0] any_nonspace();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == ASCII_SPACE);
        return b;
    endfunction

    // The first byte of every token carries restart; an empty token is a lone space.
    task automatic send_token(input logic [7:0] tok [$], input bit closed);
        bit first;
        first = 1'b1;
        foreach (tok[i])
        begin
            push_byte(tok[i], first);
            first = 1'b0;
        end
        if (closed)
            push_byte(ASCII_SPACE, first);
    endtask

    task automatic add_request();
        logic [7:0] tok [$];
        logic [7:0] b;
        int         kind;
        int         idx;
        int         n;
        int         pos;
        kind = $urandom_range(0, 99);
        idx = $urandom_range(0, NUM_METHODS - 1);
        n = method_names[idx].len();
        if (kind < 55)
        begin
            for (int i = 0; i < n; i++)
            begin
                b = 8'(method_names[idx][i]);
                if ($urandom_range(0, 1) == 1)
                    b = b | ASCII_CASE;
                tok.push_back(b);
            end
            send_token(tok, $urandom_range(0, 19) != 0);
        end
        else if (kind < 65)
        begin
            pos = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
                tok.push_back(8'(method_names[idx][i]));
            case ($urandom_range(0, 2))
                0: void'(tok.pop_back());
                1: tok.push_back(any_nonspace());
                default: tok[pos] = any_nonspace();
            endcase
            send_token(tok, 1'b1);
        end
        else if (kind < 80)
        begin
            n = $urandom_range(1, TOKEN_CAP);
            for (int i = 0; i < n; i++)
                tok.push_back(any_nonspace());
            send_token(tok, 1'b1);
        end
        else if (kind < 88)
            send_token(tok, 1'b1);
        else if (kind < 95)
        begin
            n = $urandom_range(TOKEN_CAP + 1, TOKEN_CAP + 4);
            for (int i = 0; i < n; i++)
                tok.push_back(any_nonspace());
            send_token(tok, $urandom_range(0, 1) == 1);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_byte(($urandom_range(0, 3) == 0) ? ASCII_SPACE : 8'($urandom_range(0, 255)),
                      1'b0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_if.valid <= 1'b0;
            bytes_if.data_byte <= 8'h00;
            bytes_if.restart <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (bytes_if.valid && bytes_if.ready)
            begin
                predict_byte(bytes_if.data_byte, bytes_if.restart);
                sent_count++;
            end
            if (!bytes_if.valid || bytes_if.ready)
            begin
                if (send_wait > 0 || pending_bytes.size() == 0)
                begin
                    if (send_wait > 0)
                        send_wait--;
                    bytes_if.valid <= 1'b0;
                end
                else
                begin
                    bytes_if.valid <= 1'b1;
                    bytes_if.data_byte <= pending_bytes[0].data;
                    bytes_if.restart <= pending_bytes[0].first;
                    void'(pending_bytes.pop_front());
                    send_wait = ((sent_count / 128) % 3 == 1) ? 0 : $urandom_range(0, 16);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result code=%0d status=%0d", $time,
                             result_if.method_code, result_if.parse_status);
                end
                else
                begin
                    if (result_if.method_code !== expected_verdicts[0].code)
                    begin
                        error_count++;
                        $display("%0t: method_code expected %0d actual %0d", $time,
                                 expected_verdicts[0].code, result_if.method_code);
                    end
                    if (result_if.parse_status !== expected_verdicts[0].status)
                    begin
                        error_count++;
                        $display("%0t: parse_status expected %0d actual %0d", $time,
                                 expected_verdicts[0].status, result_if.parse_status);
                    end
                    void'(expected_verdicts.pop_front());
                end
                checked_count++;
                recv_wait = ((checked_count / 16) % 3 == 1) ? 0 : $urandom_range(0, 16);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [7:0] tok [$];
        rst_n = 1'b0;
        bytes_if.valid = 1'b0;
        bytes_if.data_byte = 8'h00;
        bytes_if.restart = 1'b0;
        result_if.ready = 1'b0;
        held_count = 0;
        token_done = 1'b0;
        sent_count = 0;
        checked_count = 0;
        error_count = 0;
        cycle_count = 0;

        // Mixed-case GET, then bytes that must be ignored after the result.
        tok = '{8'h67, 8'h45, 8'h74};
        send_token(tok, 1'b1);
        push_byte(8'h78, 1'b0);
        push_byte(ASCII_SPACE, 1'b0);
        // A leading space gives the empty status.
        tok = {};
        send_token(tok, 1'b1);
        // A full store of odd bytes, then one more byte that overflows it.
        tok = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h61, 8'h7A, 8'h60, 8'h7B,
                8'h40, 8'h5B, 8'h01, 8'h6D, 8'h6B, 8'h63, 8'h6F, 8'h6C, 8'h71};
        send_token(tok, 1'b0);

        while (pending_bytes.size() < BYTE_TARGET)
            add_request();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || bytes_if.valid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
